// File: rtl/chmf_pkg.sv
// Package for the 3x3 contraharmonic mean filter: FSM state type, widths,
// divider status struct and the power lookup tables. No dependencies.
`default_nettype none
package chmf_pkg;

    localparam int MaxWidthDefault = 1024;
    localparam int NumW = 28;   // width of a numerator table entry
    localparam int DenW = 25;   // width of a denominator table entry
    localparam int S1W  = 32;   // sum of nine numerator entries
    localparam int S2W  = 28;   // sum of nine denominator entries
    localparam int RowW = 12;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_MODE   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_ACC,
        ST_START,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    typedef logic [NumW-1:0] num_tab_t [256];
    typedef logic [DenW-1:0] den_tab_t [256];

    // round(sqrt(num / den)), found as the largest lo with den*lo^2 <= num
    function automatic logic [63:0] root_rnd(input logic [127:0] num,
                                             input logic [127:0] den);
        logic [127:0] lo;
        logic [127:0] hi;
        logic [127:0] mid;
        logic [127:0] t;
        lo = '0;
        hi = 128'd1 << 31;
        for (int k = 0; k < 40; k++) begin
            if (lo < hi) begin
                mid = (lo + hi + 128'd1) >> 1;
                if (den * mid * mid <= num)
                    lo = mid;
                else
                    hi = mid - 128'd1;
            end
        end
        t = (lo << 1) + 128'd1;
        if (den * t * t < (num << 2))
            lo = lo + 128'd1;
        return lo[63:0];
    endfunction

    // Q+1 powers: p^2.5 (8 fraction bits) or p^-0.5 (24 fraction bits)
    function automatic num_tab_t build_num(input logic neg);
        num_tab_t     tab;
        logic [127:0] p;
        logic [63:0]  r;
        for (int i = 0; i < 256; i++) begin
            p = 128'(i);
            if (!neg)
                r = root_rnd((p * p * p * p * p) << 16, 128'd1);
            else if (i == 0)
                r = '0;
            else
                r = root_rnd(128'd1 << 48, p);
            tab[i] = r[NumW-1:0];
        end
        return tab;
    endfunction

    // Q powers: p^1.5 (8 fraction bits) or p^-1.5 (24 fraction bits)
    function automatic den_tab_t build_den(input logic neg);
        den_tab_t     tab;
        logic [127:0] p;
        logic [63:0]  r;
        for (int i = 0; i < 256; i++) begin
            p = 128'(i);
            if (!neg)
                r = root_rnd((p * p * p) << 16, 128'd1);
            else if (i == 0)
                r = '0;
            else
                r = root_rnd(128'd1 << 48, p * p * p);
            tab[i] = r[DenW-1:0];
        end
        return tab;
    endfunction

    localparam num_tab_t POS_NUM = build_num(1'b0);
    localparam num_tab_t NEG_NUM = build_num(1'b1);
    localparam den_tab_t POS_DEN = build_den(1'b0);
    localparam den_tab_t NEG_DEN = build_den(1'b1);

endpackage
`default_nettype wire

// File: rtl/chmf_div.sv
// Saturating 8-bit quotient divider: floor(num / den) clipped to 255, 0 for den 0.
// One quotient bit per cycle. Depends on chmf_pkg.
`default_nettype none
module chmf_div
    import chmf_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic [S1W-1:0] num,
    input  wire logic [S2W-1:0] den,
    output div_status_t         status,
    output logic [7:0]          quotient
);

    logic [S1W-1:0] rem_reg,  rem_next;
    logic [S2W-1:0] den_reg,  den_next;
    logic [7:0]     q_reg,    q_next;
    logic [2:0]     bit_reg,  bit_next;
    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [S1W+8:0] shifted;

    // one restoring step per cycle, plus a saturation check at start
    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = (S1W+9)'(den_reg) << bit_reg;
        if (start)
        begin
            rem_next = num;
            den_next = den;
            bit_next = 3'd7;
            q_next   = '0;
            if (den == '0)
                done_next = 1'b1;
            else if ((S1W+9)'(num) >= ((S1W+9)'(den) << 8))
            begin
                q_next    = 8'hFF;
                done_next = 1'b1;
            end
            else
                busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if ((S1W+9)'(rem_reg) >= shifted)
            begin
                rem_next         = rem_reg - shifted[S1W-1:0];
                q_next[bit_reg]  = 1'b1;
            end
            bit_next = bit_reg - 3'd1;
            if (bit_reg == 3'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
        bit_reg <= bit_next;
    end

    assign status   = '{busy: busy_reg, done: done_reg};
    assign quotient = q_reg;

endmodule
`default_nettype wire

// File: rtl/contraharmonic_mean_filter_3x3_top.sv
// Top level of the 3x3 contraharmonic mean filter: line memory, window,
// accumulation sequencer and output register. Depends on chmf_pkg, chmf_div.
//
// Takes one 8-bit pixel per item in raster order and gives one result item for
// each interior pixel (border pixels give none), the contraharmonic mean of
// order 1.5 or -1.5 over the 3x3 window. Every pixel is taken while the line
// memory is read, then has its window update and write-back; a pixel that
// gives a result goes on through the table lookups and sums (one window pixel
// per cycle), the divider start, the bit-serial divider and the load of the
// output register. When the quotient saturates or the divisor is zero the
// divider skips its bit-serial steps. The output register lets the next pixel
// be taken while a result waits; a new result that finds the output register
// still full holds the sequencer, and the input with it, until the waiting
// result is taken. The two previous rows share one MAX_WIDTH x 16 line memory.
`default_nettype none
module contraharmonic_mean_filter_3x3_top
    import chmf_pkg::*;
#(
    parameter int MAX_WIDTH = MaxWidthDefault,
    localparam int XW  = $clog2(MAX_WIDTH),
    localparam int ODW = ((8 + XW + RowW + 7) / 8) * 8
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    // input stream
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [7:0]     s_tdata,   // [7:0] pixel
    // output stream
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [ODW-1:0]      m_tdata,   // filtered_pixel, center_col, center_row
    output logic                m_tlast,   // last_of_frame
    // configuration
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [3:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    state_t state_reg, state_next;

    logic [10:0]     width_reg;
    logic [12:0]     height_reg;
    logic            mode_reg;

    logic [XW-1:0]   col_reg;
    logic [RowW-1:0] row_reg;
    logic [7:0]      pix_reg;
    logic [7:0]      win_pix_reg [6];
    logic [7:0]      win_reg     [9];
    logic [3:0]      acc_cnt_reg;
    logic [S1W-1:0]  s1_reg;
    logic [S2W-1:0]  s2_reg;
    logic            zero_reg;
    logic [XW-1:0]   ccol_reg;
    logic [RowW-1:0] crow_reg;
    logic            clast_reg;

    logic            out_valid_reg;
    logic [7:0]      out_pix_reg;
    logic [XW-1:0]   out_col_reg;
    logic [RowW-1:0] out_row_reg;
    logic            out_last_reg;

    logic [15:0]     line_mem [MAX_WIDTH];
    logic [15:0]     rd_data_reg;

    logic            accept;
    logic            mem_rd;
    logic            mem_wr;
    logic            div_start;
    logic            load_out;
    logic            cfg_wr;
    logic            interior;
    logic            acc_last;
    logic            out_free;

    logic [XW:0]     w_eff;
    logic [12:0]     h_eff;
    logic [XW:0]     col_ext;
    logic [12:0]     row_ext;
    logic [7:0]      up_pix;
    logic [7:0]      mid_pix;
    logic [7:0]      acc_pix;
    logic [NumW-1:0] num_val;
    logic [DenW-1:0] den_val;

    div_status_t     div_st;
    logic [7:0]      div_q;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 11'd1024;
            height_reg <= 13'd1024;
            mode_reg   <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_WIDTH:  width_reg  <= pwdata[10:0];
                REG_HEIGHT: height_reg <= pwdata[12:0];
                REG_MODE:   mode_reg   <= pwdata[0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_WIDTH:  prdata = {21'd0, width_reg};
            REG_HEIGHT: prdata = {19'd0, height_reg};
            REG_MODE:   prdata = {31'd0, mode_reg};
            default:    prdata = '0;
        endcase
    end

    // effective frame size, clamped
    always_comb
    begin
        if (width_reg < 11'd3)
            w_eff = (XW+1)'(3);
        else if (32'(width_reg) > MAX_WIDTH)
            w_eff = (XW+1)'(MAX_WIDTH);
        else
            w_eff = (XW+1)'(width_reg);
        if (height_reg < 13'd3)
            h_eff = 13'd3;
        else if (height_reg > 13'd4096)
            h_eff = 13'd4096;
        else
            h_eff = height_reg;
    end

    assign col_ext  = (XW+1)'(col_reg);
    assign row_ext  = 13'(row_reg);
    assign interior = (col_reg >= XW'(2)) && (row_reg >= RowW'(2))
                      && (col_ext < w_eff) && (row_ext < h_eff);
    assign up_pix   = rd_data_reg[15:8];
    assign mid_pix  = rd_data_reg[7:0];
    assign acc_last = (acc_cnt_reg == 4'd8);
    assign out_free = !out_valid_reg || m_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_READ;
            ST_READ:  state_next = interior ? ST_ACC : ST_IDLE;
            ST_ACC:   if (acc_last) state_next = ST_START;
            ST_START: state_next = ST_DIV;
            ST_DIV:   if (div_st.done) state_next = ST_OUT;
            ST_OUT:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        s_tready  = 1'b0;
        mem_wr    = 1'b0;
        div_start = 1'b0;
        load_out  = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_tready  = 1'b1;
            ST_READ:  mem_wr    = 1'b1;
            ST_ACC:   ;
            ST_START: div_start = 1'b1;
            ST_DIV:   ;
            ST_OUT:   load_out  = out_free;
            default:  ;
        endcase
    end

    assign accept = s_tvalid && s_tready;
    assign mem_rd = accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // line memory: upper row in the high byte, lower row in the low byte
    always_ff @(posedge clk)
    begin
        if (mem_rd)
            rd_data_reg <= line_mem[col_reg];
        if (mem_wr)
            line_mem[col_reg] <= {mid_pix, pix_reg};
    end

    // counters and window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            for (int i = 0; i < 6; i++)
                win_pix_reg[i] <= '0;
        end
        else if (mem_wr)
        begin
            win_pix_reg[0] <= win_pix_reg[1];
            win_pix_reg[1] <= up_pix;
            win_pix_reg[2] <= win_pix_reg[3];
            win_pix_reg[3] <= mid_pix;
            win_pix_reg[4] <= win_pix_reg[5];
            win_pix_reg[5] <= pix_reg;
            if (col_ext + (XW+1)'(1) >= w_eff)
            begin
                col_reg <= '0;
                row_reg <= (row_ext + 13'd1 >= h_eff) ? '0 : row_reg + RowW'(1);
            end
            else
            begin
                col_reg <= col_reg + XW'(1);
                if (row_ext >= h_eff)
                    row_reg <= '0;
            end
        end
    end

    // capture of the pixel, the nine-pixel window and the center position
    always_ff @(posedge clk)
    begin
        if (accept)
            pix_reg <= s_tdata;
        if (mem_wr)
        begin
            win_reg[0] <= win_pix_reg[0];
            win_reg[1] <= win_pix_reg[1];
            win_reg[2] <= up_pix;
            win_reg[3] <= win_pix_reg[2];
            win_reg[4] <= win_pix_reg[3];
            win_reg[5] <= mid_pix;
            win_reg[6] <= win_pix_reg[4];
            win_reg[7] <= win_pix_reg[5];
            win_reg[8] <= pix_reg;
            ccol_reg   <= col_reg - XW'(1);
            crow_reg   <= row_reg - RowW'(1);
            clast_reg  <= (col_ext == w_eff - (XW+1)'(1))
                          && (row_ext == h_eff - 13'd1);
        end
    end

    // table lookup and sums, one window pixel per cycle
    assign acc_pix = win_reg[acc_cnt_reg];
    assign num_val = mode_reg ? NEG_NUM[acc_pix] : POS_NUM[acc_pix];
    assign den_val = mode_reg ? NEG_DEN[acc_pix] : POS_DEN[acc_pix];

    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            acc_cnt_reg <= '0;
            s1_reg      <= '0;
            s2_reg      <= '0;
            zero_reg    <= 1'b0;
        end
        else if (state_reg == ST_ACC)
        begin
            acc_cnt_reg <= acc_cnt_reg + 4'd1;
            s1_reg      <= s1_reg + S1W'(num_val);
            s2_reg      <= s2_reg + S2W'(den_val);
            zero_reg    <= zero_reg || (acc_pix == 8'd0);
        end
    end

    chmf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (s1_reg),
        .den      (s2_reg),
        .status   (div_st),
        .quotient (div_q)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_pix_reg  <= (mode_reg && zero_reg) ? 8'd0 : div_q;
            out_col_reg  <= ccol_reg;
            out_row_reg  <= crow_reg;
            out_last_reg <= clast_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = ODW'({out_row_reg, out_col_reg, out_pix_reg});
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    // items are taken only while the divider is idle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !div_st.busy)
        else $error("item taken while divider busy");

    // an accepted item is followed by the line memory write-back cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_READ))
        else $error("no write-back after accepted item");

    // the divider finishes only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_st.done |-> (state_reg == ST_DIV))
        else $error("divider done outside wait state");

    // the divider is started only after a full nine-pixel accumulation
    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (acc_cnt_reg == 4'd9))
        else $error("divider started on partial sums");
`endif

endmodule
`default_nettype wire

// File: tb/chmf_checker.sv
// Checker for the 3x3 contraharmonic mean filter: watches the pixel, result
// and configuration ports, predicts each result and compares it in order.
// Depends on chmf_pkg and the ports of contraharmonic_mean_filter_3x3_top.
`timescale 1ns / 1ps
module chmf_checker
    import chmf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] pixel
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,    // [7:0] filtered_pixel, [17:8] center_col, [29:18] center_row
    input  logic        m_tlast,    // last_of_frame
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output int          errors,
    output int          pending
);

    typedef struct packed {
        logic [7:0]  value;
        logic [9:0]  col;
        logic [11:0] row;
        logic        last;
    } filt_result_t;

    filt_result_t expected_results[$];

    // fixed-point power tables, built here independently
    longint unsigned up_num[256], up_den[256], dn_num[256], dn_den[256];

    logic [10:0] width_reg;
    logic [12:0] height_reg;
    logic        mode_reg;
    logic [7:0]  row_above[1024];
    logic [7:0]  row_prev[1024];
    logic [7:0]  win_cols[6];
    int unsigned col_cnt, row_cnt;

    // round(sqrt(num / den))
    function automatic longint unsigned sqrt_round(longint unsigned num,
                                                   longint unsigned den);
        longint unsigned q, lo, hi, m, t;
        q  = num / den;
        lo = 0;
        hi = 64'd1 << 30;
        while (lo < hi) begin
            m = (lo + hi + 1) / 2;
            if (m * m <= q)
                lo = m;
            else
                hi = m - 1;
        end
        t = 2 * lo + 1;
        if (den * t * t < 4 * num)
            lo++;
        return lo;
    endfunction

    function automatic logic [7:0] contraharmonic(logic [7:0] w[9], logic neg);
        longint unsigned s1, s2, r;
        s1 = 0;
        s2 = 0;
        for (int i = 0; i < 9; i++) begin
            if (neg) begin
                if (w[i] == 8'd0)
                    return 8'd0;
                s1 += dn_num[w[i]];
                s2 += dn_den[w[i]];
            end
            else begin
                s1 += up_num[w[i]];
                s2 += up_den[w[i]];
            end
        end
        if (s2 == 0)
            return 8'd0;
        r = s1 / s2;
        return (r > 255) ? 8'd255 : r[7:0];
    endfunction

    initial
    begin
        longint unsigned p;
        for (int i = 0; i < 256; i++) begin
            p = i;
            up_num[i] = sqrt_round((p * p * p * p * p) << 16, 1);
            up_den[i] = sqrt_round((p * p * p) << 16, 1);
            dn_num[i] = i ? sqrt_round(64'd1 << 48, p) : 0;
            dn_den[i] = i ? sqrt_round(64'd1 << 48, p * p * p) : 0;
        end
        for (int i = 0; i < 1024; i++) begin
            row_above[i] = '0;
            row_prev[i]  = '0;
        end
        errors = 0;
    end

    // config shadow, pixel prediction and result compare
    always @(posedge clk or negedge rst_n)
    begin
        int unsigned w, h, x, y;
        logic [7:0] win[9];
        logic [7:0] up, md;
        filt_result_t exp_r, got;
        if (!rst_n) begin
            width_reg  <= 11'd1024;
            height_reg <= 13'd1024;
            mode_reg   <= 1'b0;
            col_cnt    <= 0;
            row_cnt    <= 0;
            pending    <= 0;
            for (int i = 0; i < 6; i++)
                win_cols[i] <= '0;
        end
        else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_WIDTH:  width_reg  <= pwdata[10:0];
                    REG_HEIGHT: height_reg <= pwdata[12:0];
                    REG_MODE:   mode_reg   <= pwdata[0];
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready) begin
                w = (width_reg < 3) ? 3 : (width_reg > 1024) ? 1024 : width_reg;
                h = (height_reg < 3) ? 3 : (height_reg > 4096) ? 4096 : height_reg;
                x = col_cnt;
                y = row_cnt;
                up = row_above[x % 1024];
                md = row_prev[x % 1024];
                win = '{win_cols[0], win_cols[1], up,
                        win_cols[2], win_cols[3], md,
                        win_cols[4], win_cols[5], s_tdata};
                if (x >= 2 && y >= 2 && x < w && y < h) begin
                    exp_r.value = contraharmonic(win, mode_reg);
                    exp_r.col   = 10'(x - 1);
                    exp_r.row   = 12'(y - 1);
                    exp_r.last  = (x == w - 1 && y == h - 1);
                    expected_results.push_back(exp_r);
                end
                row_above[x % 1024] <= md;
                row_prev[x % 1024]  <= s_tdata;
                win_cols[0] <= win_cols[1];
                win_cols[1] <= up;
                win_cols[2] <= win_cols[3];
                win_cols[3] <= md;
                win_cols[4] <= win_cols[5];
                win_cols[5] <= s_tdata;
                if (x + 1 >= w) begin
                    col_cnt <= 0;
                    row_cnt <= (y + 1 >= h) ? 0 : y + 1;
                end
                else begin
                    col_cnt <= x + 1;
                    if (y >= h)
                        row_cnt <= 0;
                end
            end

            if (m_tvalid && m_tready) begin
                got = {m_tdata[7:0], m_tdata[17:8], m_tdata[29:18], m_tlast};
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result %h", $time, got);
                end
                else begin
                    exp_r = expected_results.pop_front();
                    if (got.value !== exp_r.value || got.col !== exp_r.col ||
                        got.row !== exp_r.row || got.last !== exp_r.last) begin
                        errors++;
                        $display("%0t: mismatch expected val=%0d col=%0d row=%0d last=%0d",
                                 $time, exp_r.value, exp_r.col, exp_r.row, exp_r.last);
                        $display("%0t:          actual   val=%0d col=%0d row=%0d last=%0d",
                                 $time, got.value, got.col, got.row, got.last);
                    end
                end
            end

            // results still owed by the block
            pending <= expected_results.size();
        end
    end
endmodule

// File: tb/contraharmonic_mean_filter_3x3_top_test.sv
// Testbench top for the 3x3 contraharmonic mean filter: clock, reset, pixel
// and configuration stimulus, output back-pressure and verdict.
// Depends on contraharmonic_mean_filter_3x3_top, chmf_pkg and chmf_checker.
`timescale 1ns / 1ps
module contraharmonic_mean_filter_3x3_top_test
    import chmf_pkg::*;
;

    localparam int CycleLimit = 4000000;
    localparam int DrainCycles = 30;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;      // [7:0] pixel
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // [7:0] filtered_pixel, [17:8] center_col, [29:18] center_row
    logic        m_tlast;           // last_of_frame
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int errors, pending;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic rx_hold = 1'b0;
    int unsigned cycle_count = 0;
    int pixels_sent;

    always #1 clk = ~clk;

    contraharmonic_mean_filter_3x3_top DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    chmf_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata), .errors(errors), .pending(pending)
    );

    // result back-pressure
    always @(posedge clk)
    begin
        if (rx_hold)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_pixel(logic [7:0] p);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        do @(posedge clk); while (!s_tready);
        pixels_sent++;
    endtask

    // stop offering, let every expected result arrive and the pipe settle
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic configure(int w, int h, logic mode);
        drain();
        reg_write(REG_WIDTH, w);
        reg_write(REG_HEIGHT, h);
        reg_write(REG_MODE, 32'(mode));
    endtask

    function automatic logic [7:0] pick_pixel(logic mode);
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return (!mode || $urandom_range(9) == 0) ? 8'd0 : 8'd1;
        if (r == 1)
            return 8'd255;
        return 8'($urandom_range(255));
    endfunction

    // one frame of random pixels; optional mid-frame pause until idle
    task automatic random_frame(int w, int h, logic mode, bit pause_mid);
        for (int i = 0; i < w * h; i++) begin
            if (pause_mid && i == (w * h) / 2) begin
                s_tvalid <= 1'b0;
                do @(posedge clk); while (pending != 0);
            end
            send_pixel(pick_pixel(mode));
        end
    endtask

    initial
    begin
        int w, h, cw, ch;
        logic mode;
        logic [7:0] dir_a[16];
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: all-zero window, extremes, saturation corner, Q=1.5
        dir_a = '{0, 0, 0, 255, 0, 0, 0, 255, 0, 0, 0, 255, 255, 255, 255, 255};
        configure(4, 4, 1'b0);
        foreach (dir_a[i])
            send_pixel(dir_a[i]);
        // directed: Q=-1.5 with a zero pixel in the only window
        configure(3, 3, 1'b1);
        for (int i = 0; i < 9; i++)
            send_pixel((i == 4) ? 8'd0 : 8'd255);

        // random phases under the four idling patterns
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            pixels_sent = 0;
            while (pixels_sent < 100) begin
                w = $urandom_range(3, 12);
                h = $urandom_range(3, 8);
                mode = $urandom_range(1);
                cw = w;
                ch = h;
                // clamped register values map to the low limit
                if ($urandom_range(7) == 0) begin
                    w = 3;
                    cw = $urandom_range(2);
                end
                if ($urandom_range(7) == 0) begin
                    h = 3;
                    ch = $urandom_range(2);
                end
                if (ph == 0 && pixels_sent == 0) begin
                    // long receiver hold-off so the block backs up
                    configure(12, 8, 1'b0);
                    fork
                        begin
                            rx_hold <= 1'b1;
                            repeat (500) @(posedge clk);
                            rx_hold <= 1'b0;
                        end
                    join_none
                    random_frame(12, 8, 1'b0, 1'b0);
                end
                else begin
                    configure(cw, ch, mode);
                    random_frame(w, h, mode, ph == 1 && pixels_sent == 0);
                end
            end
        end

        drain();
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// File: sim.f
rtl/chmf_pkg.sv
rtl/chmf_div.sv
rtl/contraharmonic_mean_filter_3x3_top.sv
tb/chmf_checker.sv
tb/contraharmonic_mean_filter_3x3_top_test.sv
